// ===== hdl/abms_pkg.sv =====
package abms_pkg;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned ModeW   = 5;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned TicksW  = 5;
  localparam int unsigned IndexW  = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // opcodes
  localparam logic [OpcodeW-1:0] OP_TICK = 2'd0;
  localparam logic [OpcodeW-1:0] OP_KEEP = 2'd1;
  localparam logic [OpcodeW-1:0] OP_LOOP = 2'd2;
  localparam logic [OpcodeW-1:0] OP_STOP = 2'd3;

  // valve modes with special handling
  localparam logic [ModeW-1:0] MODE_POWER_ON      = 5'd0;
  localparam logic [ModeW-1:0] MODE_UPPER_CHG     = 5'd1;
  localparam logic [ModeW-1:0] MODE_LOWER_CHG     = 5'd2;
  localparam logic [ModeW-1:0] MODE_MIDDLE_CHG    = 5'd3;
  localparam logic [ModeW-1:0] MODE_UPPER_DIS     = 5'd4;
  localparam logic [ModeW-1:0] MODE_MIDDLE_DIS    = 5'd5;
  localparam logic [ModeW-1:0] MODE_LOWER_DIS     = 5'd6;
  localparam logic [ModeW-1:0] MODE_ALL_DIS       = 5'd8;
  localparam logic [ModeW-1:0] MODE_COUNT         = 5'd19;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FILL_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_GAP    = 2'd2;

  localparam logic [LimitW-1:0] FILL_LIMIT_RST  = 8'd200;
  localparam logic [TicksW-1:0] LOOP_PERIOD_RST = 5'd20;
  localparam logic [TicksW-1:0] LOOP_GAP_RST    = 5'd3;

  // bladder slots
  localparam int unsigned B_UPPER  = 0;
  localparam int unsigned B_MIDDLE = 1;
  localparam int unsigned B_LOWER  = 2;
  localparam int unsigned NumBladders = 3;

  typedef struct packed {
    logic [ModeW-1:0]   loop_third;
    logic [ModeW-1:0]   loop_second;
    logic [ModeW-1:0]   loop_first;
    logic [ModeW-1:0]   mode;
    logic [OpcodeW-1:0] opcode;
  } in_item_t;

  typedef struct packed {
    logic              lower_full;
    logic              middle_full;
    logic              upper_full;
    logic [ByteW-1:0]  frame_byte_sixth;
    logic [ByteW-1:0]  frame_byte_first;
    logic [ModeW-1:0]  out_mode;
  } result_t;

  typedef struct packed {
    logic [TicksW-1:0] loop_gap;
    logic [TicksW-1:0] loop_period;
    logic [LimitW-1:0] fill_limit;
  } cfg_t;

  function automatic logic [ByteW-1:0] frame_first(input logic [ModeW-1:0] m);
    logic [ByteW-1:0] b;
    unique case (m)
      5'd9:    b = 8'hC0;
      5'd10:   b = 8'hC1;
      5'd11:   b = 8'hC2;
      5'd12:   b = 8'hC4;
      5'd13:   b = 8'hC5;
      5'd14:   b = 8'hC6;
      5'd15:   b = 8'hC8;
      5'd16:   b = 8'hC9;
      5'd17:   b = 8'hCA;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] frame_sixth(input logic [ModeW-1:0] m);
    logic [ByteW-1:0] b;
    unique case (m)
      5'd1:    b = 8'h14;
      5'd2:    b = 8'h18;
      5'd3:    b = 8'h11;
      5'd4:    b = 8'h50;
      5'd5:    b = 8'h90;
      5'd6:    b = 8'hD0;
      5'd7:    b = 8'h12;
      5'd8:    b = 8'h12;
      default: b = 8'h10;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/air_bladder_mode_sequencer_top.sv =====
// Air bladder mode sequencer.
// Input stream (in_*): one command per transfer - tick, keep mode, loop of
// three modes, or stop. Only a tick yields a result, and only when the mode
// it selects is a valid code; all other commands just update state.
// Output stream (out_*): mode driven this tick, its two varying frame bytes
// and the three bladder full flags.
// Config port (cfg_*): fill limit, loop period, loop gap; write only while
// the stream is idle. Writes to unused indexes are dropped.
// A command held in the input register is applied when the sequencer steps on it;
// its result (if any) lands in the output register on that step; out_tvalid is high after it.
// Throughput: one command per cycle while the output is not stalled, set by the
// single pass through the sequencer update between the input and result registers.
// Reset (rst_n low, synchronous): keep pattern with power-on held, counters
// cleared, config back to 200 / 20 / 3, both streams empty.
// Stall: while out_tready is low and a result waits, the held command stays
// in the input register and in_tready drops once that register is full.
module air_bladder_mode_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode[1:0], mode[6:2], loop_first[11:7], loop_second[16:12],
  // loop_third[21:17], zero[23:22]
  input  logic [abms_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_mode[4:0], frame_byte_first[12:5], frame_byte_sixth[20:13],
  // upper_full[21], middle_full[22], lower_full[23]
  output logic [abms_pkg::OutDataW-1:0]     out_tdata,
  input  logic                              cfg_we,
  input  logic [abms_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [abms_pkg::CfgW-1:0]         cfg_wdata
);

  abms_pkg::in_item_t in_item;
  abms_pkg::in_item_t item;
  logic               item_valid;
  logic               step;
  logic               out_free;
  logic               res_valid;
  abms_pkg::result_t  res;
  abms_pkg::result_t  out_res;
  abms_pkg::cfg_t     cfg_r;

  assign in_item   = abms_pkg::in_item_t'(in_tdata[21:0]);
  assign out_tdata = out_res;

  // the held command moves on only when the result slot can take its result
  assign step = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fill_limit  <= abms_pkg::FILL_LIMIT_RST;
      cfg_r.loop_period <= abms_pkg::LOOP_PERIOD_RST;
      cfg_r.loop_gap    <= abms_pkg::LOOP_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abms_pkg::CFG_FILL_LIMIT:  cfg_r.fill_limit  <= cfg_wdata;
        abms_pkg::CFG_LOOP_PERIOD: cfg_r.loop_period <= cfg_wdata[abms_pkg::TicksW-1:0];
        abms_pkg::CFG_LOOP_GAP:    cfg_r.loop_gap    <= cfg_wdata[abms_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  abms_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .drain      (step),
    .item_valid (item_valid),
    .item       (item)
  );

  abms_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  abms_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .load_res   (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .free       (out_free)
  );

endmodule

// ===== hdl/abms_in_reg.sv =====
// Input holding register: one item deep, refilled in the cycle it drains.
module abms_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  abms_pkg::in_item_t in_item,
  input  logic              drain,
  output logic              item_valid,
  output abms_pkg::in_item_t item
);

  logic               valid_r;
  abms_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || drain;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hdl/abms_seq.sv =====
// Sequencer state and per-item update. State moves when step is high.
module abms_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  abms_pkg::in_item_t item,
  input  abms_pkg::cfg_t     cfg,
  output logic               res_valid,
  output abms_pkg::result_t  res
);

  logic                              looping_r, looping_nxt;
  logic [abms_pkg::ModeW-1:0]        held_mode_r, held_mode_nxt;
  logic                              first_pending_r, first_pending_nxt;
  logic [abms_pkg::ModeW-1:0]        loop_modes_r [abms_pkg::NumBladders];
  logic [abms_pkg::ModeW-1:0]        loop_modes_nxt [abms_pkg::NumBladders];
  logic [abms_pkg::TicksW-1:0]       step_ticks_r, step_ticks_nxt;
  logic [abms_pkg::IndexW-1:0]       step_index_r, step_index_nxt;
  logic [abms_pkg::ModeW-1:0]        current_mode_r, current_mode_nxt;
  logic [abms_pkg::LimitW-1:0]       fill_counts_r [abms_pkg::NumBladders];
  logic [abms_pkg::LimitW-1:0]       fill_counts_nxt [abms_pkg::NumBladders];

  logic [abms_pkg::TicksW-1:0]       ticks_inc;
  logic [abms_pkg::IndexW-1:0]       idx_rd;
  logic [abms_pkg::LimitW:0]         cnt_inc;
  logic [abms_pkg::LimitW-1:0]       cnt_sel;
  logic                              charging;
  logic [1:0]                        chg_slot;
  logic                              forced;
  logic [abms_pkg::ModeW-1:0]        om;

  always_comb begin
    looping_nxt       = looping_r;
    held_mode_nxt     = held_mode_r;
    first_pending_nxt = first_pending_r;
    loop_modes_nxt    = loop_modes_r;
    step_ticks_nxt    = step_ticks_r;
    step_index_nxt    = step_index_r;
    current_mode_nxt  = current_mode_r;
    fill_counts_nxt   = fill_counts_r;
    ticks_inc         = step_ticks_r + 1'b1;
    idx_rd            = (step_index_r > 2'd2) ? 2'd0 : step_index_r;
    charging          = 1'b0;
    chg_slot          = 2'(abms_pkg::B_UPPER);
    forced            = 1'b0;
    res_valid         = 1'b0;
    cnt_sel           = '0;
    cnt_inc           = '0;

    unique case (item.opcode)
      abms_pkg::OP_KEEP: begin
        if (item.mode < abms_pkg::MODE_COUNT) begin
          if (item.mode == abms_pkg::MODE_ALL_DIS) begin
            // all-discharge runs as a loop of the three discharge modes
            looping_nxt       = 1'b1;
            loop_modes_nxt[0] = abms_pkg::MODE_UPPER_DIS;
            loop_modes_nxt[1] = abms_pkg::MODE_MIDDLE_DIS;
            loop_modes_nxt[2] = abms_pkg::MODE_LOWER_DIS;
          end else begin
            held_mode_nxt     = item.mode;
            first_pending_nxt = 1'b1;
            looping_nxt       = 1'b0;
          end
        end
      end
      abms_pkg::OP_LOOP: begin
        looping_nxt       = 1'b1;
        loop_modes_nxt[0] = item.loop_first;
        loop_modes_nxt[1] = item.loop_second;
        loop_modes_nxt[2] = item.loop_third;
      end
      abms_pkg::OP_STOP: begin
        looping_nxt    = 1'b0;
        held_mode_nxt  = abms_pkg::MODE_POWER_ON;
        step_ticks_nxt = '0;
        step_index_nxt = '0;
        loop_modes_nxt[0] = '0;
        loop_modes_nxt[1] = '0;
        loop_modes_nxt[2] = '0;
      end
      default: begin
        // tick: pick this tick's mode
        if (looping_r) begin
          step_ticks_nxt = ticks_inc;
          if (ticks_inc < cfg.loop_gap) begin
            current_mode_nxt = abms_pkg::MODE_POWER_ON;
          end else if (ticks_inc < cfg.loop_period) begin
            current_mode_nxt = loop_modes_r[idx_rd];
          end else begin
            // step end: advance, mode from last tick is driven again
            step_index_nxt = (step_index_r >= 2'd2) ? 2'd0 : step_index_r + 2'd1;
            step_ticks_nxt = '0;
          end
        end else begin
          if (first_pending_r) begin
            current_mode_nxt  = abms_pkg::MODE_POWER_ON;
            first_pending_nxt = 1'b0;
          end else begin
            current_mode_nxt = held_mode_r;
          end
          step_ticks_nxt = '0;
          step_index_nxt = '0;
        end

        if (current_mode_nxt < abms_pkg::MODE_COUNT) begin
          res_valid = 1'b1;
          case (current_mode_nxt)
            abms_pkg::MODE_UPPER_CHG: begin
              charging = 1'b1;
              chg_slot = 2'(abms_pkg::B_UPPER);
            end
            abms_pkg::MODE_MIDDLE_CHG: begin
              charging = 1'b1;
              chg_slot = 2'(abms_pkg::B_MIDDLE);
            end
            abms_pkg::MODE_LOWER_CHG: begin
              charging = 1'b1;
              chg_slot = 2'(abms_pkg::B_LOWER);
            end
            abms_pkg::MODE_UPPER_DIS:  fill_counts_nxt[abms_pkg::B_UPPER]  = '0;
            abms_pkg::MODE_MIDDLE_DIS: fill_counts_nxt[abms_pkg::B_MIDDLE] = '0;
            abms_pkg::MODE_LOWER_DIS:  fill_counts_nxt[abms_pkg::B_LOWER]  = '0;
            default: ;
          endcase
          if (charging) begin
            cnt_sel = fill_counts_r[chg_slot];
            // no wrap: a counter at the top stays full
            cnt_inc = {1'b0, cnt_sel} + 1'b1;
            if (cnt_inc >= {1'b0, cfg.fill_limit}) begin
              fill_counts_nxt[chg_slot] = cfg.fill_limit;
              forced = 1'b1;
            end else begin
              fill_counts_nxt[chg_slot] = cnt_inc[abms_pkg::LimitW-1:0];
            end
          end
        end
      end
    endcase

    om = forced ? abms_pkg::MODE_POWER_ON : current_mode_nxt;
    res.out_mode         = om;
    res.frame_byte_first = abms_pkg::frame_first(om);
    res.frame_byte_sixth = abms_pkg::frame_sixth(om);
    res.upper_full  = fill_counts_nxt[abms_pkg::B_UPPER]  >= cfg.fill_limit;
    res.middle_full = fill_counts_nxt[abms_pkg::B_MIDDLE] >= cfg.fill_limit;
    res.lower_full  = fill_counts_nxt[abms_pkg::B_LOWER]  >= cfg.fill_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looping_r       <= 1'b0;
      held_mode_r     <= abms_pkg::MODE_POWER_ON;
      first_pending_r <= 1'b0;
      step_ticks_r    <= '0;
      step_index_r    <= '0;
      current_mode_r  <= abms_pkg::MODE_POWER_ON;
      for (int i = 0; i < abms_pkg::NumBladders; i++) begin
        loop_modes_r[i]  <= '0;
        fill_counts_r[i] <= '0;
      end
    end else if (step) begin
      looping_r       <= looping_nxt;
      held_mode_r     <= held_mode_nxt;
      first_pending_r <= first_pending_nxt;
      step_ticks_r    <= step_ticks_nxt;
      step_index_r    <= step_index_nxt;
      current_mode_r  <= current_mode_nxt;
      loop_modes_r    <= loop_modes_nxt;
      fill_counts_r   <= fill_counts_nxt;
    end
  end

endmodule

// ===== hdl/abms_out_reg.sv =====
// Result register; a step loads a result or clears out_tvalid.
module abms_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              load_valid,
  input  abms_pkg::result_t load_res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output abms_pkg::result_t out_res,
  output logic              free
);

  logic              valid_r;
  abms_pkg::result_t res_r;

  assign out_tvalid = valid_r;
  assign out_res    = res_r;
  assign free       = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
